FILE: rtl/abd_pkg.sv
// ----------------------------------------------------------------------------
// abd_pkg : shared types and constants of the area box downscaler
// Field widths, register indexes, controller states and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package abd_pkg;

  localparam int PIX_W      = 8;
  localparam int COORD_W    = 12;
  localparam int CFG_DIM_W  = 15;
  localparam int CFG_EDGE_W = 13;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int LANES      = 3;
  localparam int IN_DATA_W  = 3 * PIX_W;
  localparam int OUT_DATA_W = 3 * PIX_W + 2 * COORD_W;

  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_LIM  = 2'd2;

  localparam logic [CFG_DIM_W-1:0]  CFG_DIM_RST  = 15'd1;
  localparam logic [CFG_EDGE_W-1:0] CFG_EDGE_RST = 13'd4096;
  localparam logic [PIX_W-1:0]      PIX_MAX      = 8'd255;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_SZ_CLAMP,
    ST_SZ_MUL,
    ST_SZ_DIV,
    ST_SZ_WAIT,
    ST_IDLE,
    ST_RD,
    ST_MUL,
    ST_ACC,
    ST_EMIT,
    ST_DIV,
    ST_OUT
  } abd_state_t;

  typedef struct packed {
    logic       clear;
    logic       size_clamp;
    logic       size_mul;
    logic       size_div;
    logic       size_load;
    logic       accept;
    logic       rd;
    logic       mul;
    logic       acc;
    logic       emit_div;
    logic       out_load;
    logic [1:0] tgt;       // bit 0: next column, bit 1: next row
  } abd_cmd_t;

  typedef struct packed {
    logic cfg_hit;
    logic clr_done;
    logic div_done;
    logic two_x;
    logic two_y;
    logic emit;
  } abd_sts_t;

endpackage

`default_nettype wire

FILE: rtl/abd_div.sv
// ----------------------------------------------------------------------------
// abd_div : three-lane restoring divider
// Shared divisor, one quotient bit per cycle per lane.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module abd_div #(
  parameter int NUM_W = 37,
  parameter int DEN_W = 30,
  parameter int Q_W   = 13
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    start_i,
  input  wire logic [abd_pkg::LANES-1:0][NUM_W-1:0]    num_i,
  input  wire logic [DEN_W-1:0]                        den_i,
  output logic      [abd_pkg::LANES-1:0][Q_W-1:0]      quot_o,
  output logic                                         done_o
);

  localparam int SH_W  = DEN_W + Q_W - 1;
  localparam int CMP_W = (NUM_W > SH_W) ? NUM_W : SH_W;
  localparam int CW    = $clog2(Q_W);

  logic                                        busy_r;
  logic                                        done_r;
  logic [CW-1:0]                               cnt_r;
  logic [SH_W-1:0]                             dsh_r;
  logic [abd_pkg::LANES-1:0][NUM_W-1:0]        rem_r;
  logic [abd_pkg::LANES-1:0][Q_W-1:0]          q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(Q_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - CW'(1);
        end
      end
    end
  end

  // one trial subtract per lane against the shifted divisor
  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r <= num_i;
      dsh_r <= SH_W'(den_i) << (Q_W - 1);
      q_r   <= '0;
    end else if (busy_r) begin
      for (int i = 0; i < abd_pkg::LANES; i++) begin
        if (CMP_W'(rem_r[i]) >= CMP_W'(dsh_r)) begin
          rem_r[i] <= rem_r[i] - NUM_W'(dsh_r);
          q_r[i]   <= {q_r[i][Q_W-2:0], 1'b1};
        end else begin
          q_r[i]   <= {q_r[i][Q_W-2:0], 1'b0};
        end
      end
      dsh_r <= dsh_r >> 1;
    end
  end

  assign quot_o = q_r;
  assign done_o = done_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> !busy_r)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

FILE: rtl/abd_ctrl.sv
// ----------------------------------------------------------------------------
// abd_ctrl : sequencer of the area box downscaler
// Clearing pass, size derivation, per-pixel read-modify-write over up to
// four output boxes, mean division and the output register handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module abd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic              out_tready,
  output logic                   out_tvalid,
  input  wire abd_pkg::abd_sts_t sts,
  output abd_pkg::abd_cmd_t      cmd
);

  abd_pkg::abd_state_t state_r, state_nxt;
  logic [1:0]          tgt_r, tgt_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= abd_pkg::ST_CLEAR;
      tgt_r       <= 2'b00;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tgt_r       <= tgt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.tgt   = tgt_r;
    state_nxt = state_r;
    tgt_nxt   = tgt_r;
    in_tready = 1'b0;
    case (state_r)
      abd_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_done) begin
          state_nxt = abd_pkg::ST_SZ_CLAMP;
        end
      end
      abd_pkg::ST_SZ_CLAMP: begin
        cmd.size_clamp = 1'b1;
        state_nxt      = abd_pkg::ST_SZ_MUL;
      end
      abd_pkg::ST_SZ_MUL: begin
        cmd.size_mul = 1'b1;
        state_nxt    = abd_pkg::ST_SZ_DIV;
      end
      abd_pkg::ST_SZ_DIV: begin
        cmd.size_div = 1'b1;
        state_nxt    = abd_pkg::ST_SZ_WAIT;
      end
      abd_pkg::ST_SZ_WAIT: begin
        if (sts.div_done) begin
          cmd.size_load = 1'b1;
          state_nxt     = abd_pkg::ST_IDLE;
        end
      end
      abd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          tgt_nxt    = 2'b00;
          state_nxt  = abd_pkg::ST_RD;
        end
      end
      abd_pkg::ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = abd_pkg::ST_MUL;
      end
      abd_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = abd_pkg::ST_ACC;
      end
      abd_pkg::ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.emit ? abd_pkg::ST_EMIT : abd_pkg::ST_IDLE;
        // skip boxes the pixel does not reach
        case (tgt_r)
          2'b00: begin
            if (sts.two_x) begin
              tgt_nxt = 2'b01; state_nxt = abd_pkg::ST_RD;
            end else if (sts.two_y) begin
              tgt_nxt = 2'b10; state_nxt = abd_pkg::ST_RD;
            end
          end
          2'b01: begin
            if (sts.two_y) begin
              tgt_nxt = 2'b10; state_nxt = abd_pkg::ST_RD;
            end
          end
          2'b10: begin
            if (sts.two_x) begin
              tgt_nxt = 2'b11; state_nxt = abd_pkg::ST_RD;
            end
          end
          default: begin
            tgt_nxt = tgt_r;
          end
        endcase
      end
      abd_pkg::ST_EMIT: begin
        cmd.emit_div = 1'b1;
        state_nxt    = abd_pkg::ST_DIV;
      end
      abd_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = abd_pkg::ST_OUT;
        end
      end
      abd_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = abd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = abd_pkg::ST_CLEAR;
      end
    endcase
    if (sts.cfg_hit) begin
      state_nxt = abd_pkg::ST_CLEAR;
    end
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

  a_mem_cmds: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear, cmd.accept, cmd.rd, cmd.mul, cmd.acc}))
    else $error("overlapping memory commands");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == abd_pkg::ST_SZ_WAIT || state_r == abd_pkg::ST_DIV))
    else $error("divider finished with no job waiting");

  a_tgt_col: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == abd_pkg::ST_RD && tgt_r[0]) |-> sts.two_x)
    else $error("second column visited for a one-column pixel");

  a_tgt_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == abd_pkg::ST_RD && tgt_r[1]) |-> sts.two_y)
    else $error("second row visited for a one-row pixel");

endmodule

`default_nettype wire

FILE: rtl/abd_datapath.sv
// ----------------------------------------------------------------------------
// abd_datapath : arithmetic and storage of the area box downscaler
// Config registers, size derivation, box position tracking, line sum
// memory with read-modify-write, mean divider and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module abd_datapath #(
  parameter int MAX_IN_DIM  = 16384,
  parameter int MAX_OUT_DIM = 4096
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire abd_pkg::abd_cmd_t                     cmd,
  output abd_pkg::abd_sts_t                          sts,
  input  wire logic [abd_pkg::IN_DATA_W-1:0]         in_tdata,
  input  wire logic                                  cfg_we,
  input  wire logic [abd_pkg::CFG_IDX_W-1:0]         cfg_addr,
  input  wire logic [abd_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  output logic      [abd_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                       out_tlast
);

  localparam int PIX_W  = abd_pkg::PIX_W;
  localparam int LANES  = abd_pkg::LANES;
  localparam int C      = $clog2(MAX_IN_DIM);
  localparam int IW     = $clog2(MAX_IN_DIM + 1);
  localparam int CO     = $clog2(MAX_OUT_DIM);
  localparam int OW     = $clog2(MAX_OUT_DIM + 1);
  localparam int PW     = C + CO + 1;            // scaled positions
  localparam int XW     = CO;                    // output box index
  localparam int WPW    = 2 * OW;                // weight product
  localparam int PRW    = PIX_W + WPW;
  localparam int SUM_W  = PIX_W + 2 * C;
  localparam int AREA_W = 2 * C + 1;
  localparam int DEN_W  = 2 * C + 2;
  localparam int SZN_W  = C + CO + 2;
  localparam int NUM_W  = (SUM_W + 1 > SZN_W) ? SUM_W + 1 : SZN_W;
  localparam int Q_W    = (OW > 9) ? OW : 9;
  localparam int DEPTH  = 2 * MAX_OUT_DIM;
  localparam int AW     = $clog2(DEPTH);

  // configuration
  logic [abd_pkg::CFG_DIM_W-1:0]  cfg_w_r, cfg_h_r;
  logic [abd_pkg::CFG_EDGE_W-1:0] cfg_e_r;
  logic                           cfg_hit;
  logic [AW-1:0]                  clr_addr_r;

  // derived frame geometry
  logic [IW-1:0]     w_r, h_r, l_r;
  logic [OW-1:0]     e_r, ow_r, oh_r;
  logic [IW+OW-1:0]  we_r, he_r;
  logic [AREA_W-1:0] area_r;

  // running position inside the frame
  logic [PW-1:0] px_r, bx_r, py_r, by_r;
  logic [XW-1:0] x0_r, y0_r;
  logic [IW-1:0] sx_r, sy_r;

  // current pixel
  logic [LANES-1:0][PIX_W-1:0] pix_r;
  logic [XW-1:0]               x0c_r, y0c_r;
  logic [OW-1:0]               wx0_r, wx1_r, wy0_r, wy1_r;
  logic                        two_x_r, two_y_r, emit_r, fend_r;

  // read-modify-write path
  logic [AW-1:0]               addr_r;
  logic [WPW-1:0]              wp_r;
  logic [LANES*SUM_W-1:0]      rd_r;
  logic [LANES-1:0][PRW-1:0]   prod_r;
  logic [LANES-1:0][SUM_W-1:0] acc_r;
  logic [LANES*SUM_W-1:0]      mem [0:DEPTH-1];

  // output register
  logic [LANES-1:0][PIX_W-1:0]     opix_r;
  logic [abd_pkg::COORD_W-1:0]     ocol_r, orow_r;
  logic                            olast_r;

  // combinational
  logic [IW-1:0]  w_cl, h_cl;
  logic [OW-1:0]  e_cl;
  logic [PW-1:0]  ex, ey;
  logic           two_x, two_y, col_last, row_last;
  logic [XW-1:0]  xt;
  logic           bank;
  logic [AW-1:0]  addr_t;
  logic [OW-1:0]  wx, wy;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [LANES*SUM_W-1:0]             mem_wdata;
  logic [LANES-1:0][SUM_W-1:0]        sum;
  logic                               div_start;
  logic [LANES-1:0][NUM_W-1:0]        div_num;
  logic [DEN_W-1:0]                   div_den;
  logic [LANES-1:0][Q_W-1:0]          quot;
  logic                               div_done;
  logic [OW-1:0]                      q_w, q_h;

  assign cfg_hit = cfg_we && (cfg_addr == abd_pkg::REG_IN_WIDTH ||
                              cfg_addr == abd_pkg::REG_IN_HEIGHT ||
                              cfg_addr == abd_pkg::REG_EDGE_LIM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r    <= abd_pkg::CFG_DIM_RST;
      cfg_h_r    <= abd_pkg::CFG_DIM_RST;
      cfg_e_r    <= abd_pkg::CFG_EDGE_RST;
      clr_addr_r <= '0;
    end else begin
      if (cfg_we && cfg_addr == abd_pkg::REG_IN_WIDTH) begin
        cfg_w_r <= cfg_wdata;
      end
      if (cfg_we && cfg_addr == abd_pkg::REG_IN_HEIGHT) begin
        cfg_h_r <= cfg_wdata;
      end
      if (cfg_we && cfg_addr == abd_pkg::REG_EDGE_LIM) begin
        cfg_e_r <= cfg_wdata[abd_pkg::CFG_EDGE_W-1:0];
      end
      if (cfg_hit) begin
        clr_addr_r <= '0;
      end else if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  // a zero side acts as one, oversize saturates
  assign w_cl = (cfg_w_r == '0) ? IW'(1) :
                (32'(cfg_w_r) > 32'(MAX_IN_DIM)) ? IW'(MAX_IN_DIM) : IW'(cfg_w_r);
  assign h_cl = (cfg_h_r == '0) ? IW'(1) :
                (32'(cfg_h_r) > 32'(MAX_IN_DIM)) ? IW'(MAX_IN_DIM) : IW'(cfg_h_r);
  assign e_cl = (32'(cfg_e_r) > 32'(MAX_OUT_DIM)) ? OW'(MAX_OUT_DIM) : OW'(cfg_e_r);

  assign q_w = (quot[0] == '0) ? OW'(1) : OW'(quot[0]);
  assign q_h = (quot[1] == '0) ? OW'(1) : OW'(quot[1]);

  // pixel footprint against the current box edges
  assign ex       = px_r + PW'(ow_r);
  assign ey       = py_r + PW'(oh_r);
  assign two_x    = ex > bx_r;
  assign two_y    = ey > by_r;
  assign col_last = sx_r == w_r - IW'(1);
  assign row_last = sy_r == h_r - IW'(1);

  always_ff @(posedge clk) begin
    if (cmd.size_clamp) begin
      w_r <= w_cl;
      h_r <= h_cl;
      e_r <= e_cl;
      l_r <= (w_cl > h_cl) ? w_cl : h_cl;
    end
    if (cmd.size_mul) begin
      we_r   <= (IW+OW)'(w_r) * (IW+OW)'(e_r);
      he_r   <= (IW+OW)'(h_r) * (IW+OW)'(e_r);
      area_r <= AREA_W'(w_r) * AREA_W'(h_r);
    end
    if (cmd.size_load) begin
      ow_r <= (32'(l_r) <= 32'(e_r)) ? OW'(w_r) : q_w;
      oh_r <= (32'(l_r) <= 32'(e_r)) ? OW'(h_r) : q_h;
      px_r <= '0;
      bx_r <= PW'(w_r);
      x0_r <= '0;
      sx_r <= '0;
      py_r <= '0;
      by_r <= PW'(h_r);
      y0_r <= '0;
      sy_r <= '0;
    end
    if (cmd.accept) begin
      pix_r[0] <= in_tdata[PIX_W-1:0];
      pix_r[1] <= in_tdata[2*PIX_W-1:PIX_W];
      pix_r[2] <= in_tdata[3*PIX_W-1:2*PIX_W];
      x0c_r    <= x0_r;
      y0c_r    <= y0_r;
      two_x_r  <= two_x;
      two_y_r  <= two_y;
      wx0_r    <= two_x ? OW'(bx_r - px_r) : ow_r;
      wx1_r    <= OW'(ex - bx_r);
      wy0_r    <= two_y ? OW'(by_r - py_r) : oh_r;
      wy1_r    <= OW'(ey - by_r);
      emit_r   <= (ex == bx_r) && (ey == by_r);
      fend_r   <= col_last && row_last;
      if (col_last) begin
        px_r <= '0;
        bx_r <= PW'(w_r);
        x0_r <= '0;
        sx_r <= '0;
        if (row_last) begin
          py_r <= '0;
          by_r <= PW'(h_r);
          y0_r <= '0;
          sy_r <= '0;
        end else begin
          py_r <= ey;
          sy_r <= sy_r + IW'(1);
          if (ey >= by_r) begin
            y0_r <= y0_r + XW'(1);
            by_r <= by_r + PW'(h_r);
          end
        end
      end else begin
        px_r <= ex;
        sx_r <= sx_r + IW'(1);
        if (ex >= bx_r) begin
          x0_r <= x0_r + XW'(1);
          bx_r <= bx_r + PW'(w_r);
        end
      end
    end
    if (cmd.rd) begin
      addr_r <= addr_t;
      wp_r   <= wx * wy;
    end
    if (cmd.mul) begin
      for (int i = 0; i < LANES; i++) begin
        prod_r[i] <= PRW'(pix_r[i]) * PRW'(wp_r);
      end
    end
    if (cmd.acc) begin
      acc_r <= sum;
    end
    if (cmd.out_load) begin
      for (int i = 0; i < LANES; i++) begin
        opix_r[i] <= (quot[i] > Q_W'(abd_pkg::PIX_MAX)) ? abd_pkg::PIX_MAX
                                                          : PIX_W'(quot[i]);
      end
      ocol_r  <= abd_pkg::COORD_W'(x0c_r);
      orow_r  <= abd_pkg::COORD_W'(y0c_r);
      olast_r <= fend_r;
    end
  end

  // target box: column x0 or x0+1, bank of row y0 or the other one
  assign xt     = x0c_r + XW'(cmd.tgt[0]);
  assign bank   = y0c_r[0] ^ cmd.tgt[1];
  assign addr_t = bank ? AW'(xt) + AW'(MAX_OUT_DIM) : AW'(xt);
  assign wx     = cmd.tgt[0] ? wx1_r : wx0_r;
  assign wy     = cmd.tgt[1] ? wy1_r : wy0_r;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sum[i] = rd_r[i*SUM_W +: SUM_W] + SUM_W'(prod_r[i]);
    end
  end

  // a closed box is read out and cleared in the same write
  assign mem_we    = cmd.clear || cmd.acc;
  assign mem_waddr = cmd.clear ? clr_addr_r : addr_r;
  assign mem_wdata = (cmd.clear || emit_r) ? '0 : sum;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd) begin
      rd_r <= mem[addr_t];
    end
  end

  // size job: round(side * e / l) as (2*side*e + l) / (2*l)
  // mean job: (2*sum + area) / (2*area)
  assign div_start = cmd.size_div || cmd.emit_div;
  always_comb begin
    if (cmd.size_div) begin
      div_num[0] = (NUM_W'(we_r) << 1) + NUM_W'(l_r);
      div_num[1] = (NUM_W'(he_r) << 1) + NUM_W'(l_r);
      div_num[2] = '0;
      div_den    = DEN_W'(l_r) << 1;
    end else begin
      for (int i = 0; i < LANES; i++) begin
        div_num[i] = (NUM_W'(acc_r[i]) << 1) + NUM_W'(area_r);
      end
      div_den = DEN_W'(area_r) << 1;
    end
  end

  abd_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .Q_W   (Q_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (quot),
    .done_o  (div_done)
  );

  assign sts.cfg_hit  = cfg_hit;
  assign sts.clr_done = clr_addr_r == AW'(DEPTH - 1);
  assign sts.div_done = div_done;
  assign sts.two_x    = two_x_r;
  assign sts.two_y    = two_y_r;
  assign sts.emit     = emit_r;

  assign out_tdata = {orow_r, ocol_r, opix_r[2], opix_r[1], opix_r[0]};
  assign out_tlast = olast_r;

  a_emit_single: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.acc && emit_r) |-> (cmd.tgt == 2'b00 && !two_x_r && !two_y_r))
    else $error("closing pixel spans more than one box");

endmodule

`default_nettype wire

FILE: rtl/area_box_downscaler_unit.sv
// ----------------------------------------------------------------------------
// area_box_downscaler_unit : area-weighted box downscaler for RGB rasters
// Fits the longer side within the edge limit and emits each output pixel as
// the rounded, overlap-weighted mean of the input pixels that cover it.
// ----------------------------------------------------------------------------
//
//   channel  ports                          word
//   -------  -----------------------------  ---------------------------------
//   in       in_tvalid/in_tready/in_tdata   one input pixel, raster order
//   out      out_tvalid/out_tready/out_*    one output pixel, tlast = frame end
//   cfg      cfg_we/cfg_addr/cfg_wdata      register write, no read-back
//
// Sequence: a pixel is accepted, then each output box it touches (one to
//   four boxes) is read, weighted and accumulated in turn; the pixel that
//   closes a box also runs the mean divider. The read-modify-write of the
//   line sum memory sets the pace.
// Reset and every register write: a clearing pass zeroes all 2*MAX_OUT_DIM
//   line sums, then the clamp, multiply and divide steps derive the output
//   size; no pixel is taken meanwhile, cfg writes still are.
// Stalls: a finished pixel sits in the output register while the next
//   input pixel is taken; a second one waits in the divider until the first
//   has left.
//
// Output box positions are tracked in units scaled by the output size, so
// every overlap is an exact integer and the mean divides by in_width *
// in_height.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module area_box_downscaler_unit #(
  parameter int MAX_IN_DIM  = 16384,
  parameter int MAX_OUT_DIM = 4096
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // in_tdata: red_in [7:0], green_in [15:8], blue_in [23:16]
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [abd_pkg::IN_DATA_W-1:0]      in_tdata,
  // out_tdata: red_out [7:0], green_out [15:8], blue_out [23:16],
  //            out_col [35:24], out_row [47:36]
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic      [abd_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                    out_tlast,   // frame_end
  // 0: in_width, 1: in_height, 2: edge limit
  input  wire logic                               cfg_we,
  input  wire logic [abd_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  wire logic [abd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  abd_pkg::abd_cmd_t cmd;
  abd_pkg::abd_sts_t sts;

  // sequencing only; no arithmetic here
  abd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .sts        (sts),
    .cmd        (cmd)
  );

  // config registers, geometry, line sums, divider, output register
  abd_datapath #(
    .MAX_IN_DIM  (MAX_IN_DIM),
    .MAX_OUT_DIM (MAX_OUT_DIM)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench : self-checking bench for area_box_downscaler_unit
// Streams RGB pixels through the downscaler under a range of frame sizes and
// edge limits, predicts every emitted output pixel in step with the stream
// and compares each word field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int IN_DIM_CAP  = 16384;
  localparam int OUT_DIM_CAP = 4096;
  localparam int SETTLE      = 120;   // cycles after the last word: divider + box updates

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] col;
    logic [11:0] row;
    logic        last;
  } box_pix_t;

  // directed rows: pixel in, and the output pixel typed in by hand
  typedef struct {
    logic [23:0] pix;
    box_pix_t    want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [abd_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [abd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [abd_pkg::CFG_IDX_W-1:0] cfg_addr = abd_pkg::REG_IN_WIDTH;
  logic [abd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  area_box_downscaler_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Predictor state: register copies, counters and the two line banks
  // --------------------------------------------------------------------------
  int unsigned      width_reg = 1, height_reg = 1, edge_reg = 4096;
  longint unsigned  box_w = 1, box_h = 1;        // derived output size
  longint unsigned  col_cnt = 0, row_cnt = 0;
  longint unsigned  red_sum [2*OUT_DIM_CAP];
  longint unsigned  grn_sum [2*OUT_DIM_CAP];
  longint unsigned  blu_sum [2*OUT_DIM_CAP];

  box_pix_t         pending_q[$];
  int               mismatches = 0;
  int               words_in = 0, words_out = 0, frames_done = 0, phases = 0;

  function automatic longint unsigned clamp_side(int unsigned v);
    if (v == 0) return 1;
    if (v > IN_DIM_CAP) return IN_DIM_CAP;
    return v;
  endfunction

  function automatic longint unsigned fit_side(longint unsigned s, longint unsigned e,
                                               longint unsigned l);
    longint unsigned r;
    if (l <= e) return s;
    r = (2 * s * e + l) / (2 * l);   // round half up
    return (r < 1) ? 1 : r;
  endfunction

  task automatic derive_box();
    longint unsigned w, h, e, l;
    w = clamp_side(width_reg);
    h = clamp_side(height_reg);
    e = (edge_reg > OUT_DIM_CAP) ? OUT_DIM_CAP : edge_reg;
    l = (w > h) ? w : h;
    box_w = fit_side(w, e, l);
    box_h = fit_side(h, e, l);
  endtask

  // every register write restarts the frame and empties the banks
  task automatic restart_frame();
    for (int i = 0; i < 2*OUT_DIM_CAP; i++) begin
      red_sum[i] = 0; grn_sum[i] = 0; blu_sum[i] = 0;
    end
    col_cnt = 0;
    row_cnt = 0;
    derive_box();
  endtask

  function automatic longint unsigned round_mean(longint unsigned s, longint unsigned a);
    longint unsigned m;
    m = (2 * s + a) / (2 * a);
    return (m > 255) ? 255 : m;
  endfunction

  task automatic add_box(longint unsigned x, longint unsigned bank, longint unsigned wt,
                         logic [23:0] pix);
    int i;
    i = int'((bank & 1) * OUT_DIM_CAP + (x % OUT_DIM_CAP));
    red_sum[i] += pix[7:0] * wt;
    grn_sum[i] += pix[15:8] * wt;
    blu_sum[i] += pix[23:16] * wt;
  endtask

  // accumulate one pixel; returns 1 with the closed output pixel if it ends a box
  task automatic accumulate_pixel(input logic [23:0] pix, output bit closed,
                                  output box_pix_t res);
    longint unsigned w, h, sx, sy, x0, y0, bx, by, ex, ey, wx0, wx1, wy0, wy1, bank;
    bit two_x, two_y;
    int i;
    w = clamp_side(width_reg);
    h = clamp_side(height_reg);
    closed = 0;
    res = '0;
    if (col_cnt >= w || row_cnt >= h) begin
      col_cnt = 0; row_cnt = 0;
    end
    if (col_cnt == 0 && row_cnt == 0) derive_box();
    sx = col_cnt;
    sy = row_cnt;
    x0 = sx * box_w / w;
    bx = (x0 + 1) * w;
    ex = (sx + 1) * box_w;
    two_x = ex > bx;
    wx0 = two_x ? bx - sx * box_w : box_w;
    wx1 = two_x ? ex - bx : 0;
    y0 = sy * box_h / h;
    by = (y0 + 1) * h;
    ey = (sy + 1) * box_h;
    two_y = ey > by;
    wy0 = two_y ? by - sy * box_h : box_h;
    wy1 = two_y ? ey - by : 0;
    bank = y0 & 1;
    add_box(x0, bank, wx0 * wy0, pix);
    if (two_x) add_box(x0 + 1, bank, wx1 * wy0, pix);
    if (two_y) begin
      add_box(x0, bank ^ 1, wx0 * wy1, pix);
      if (two_x) add_box(x0 + 1, bank ^ 1, wx1 * wy1, pix);
    end
    if (ex % w == 0 && ey % h == 0) begin
      i = int'(((ey / h - 1) & 1) * OUT_DIM_CAP + ((ex / w - 1) % OUT_DIM_CAP));
      res.red   = 8'(round_mean(red_sum[i], w * h));
      res.green = 8'(round_mean(grn_sum[i], w * h));
      res.blue  = 8'(round_mean(blu_sum[i], w * h));
      res.col   = 12'((ex / w - 1) & 12'hFFF);
      res.row   = 12'((ey / h - 1) & 12'hFFF);
      res.last  = (sx == w - 1 && sy == h - 1);
      red_sum[i] = 0; grn_sum[i] = 0; blu_sum[i] = 0;
      closed = 1;
    end
    if (sx + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (sy + 1 >= h) ? 0 : sy + 1;
    end else begin
      col_cnt = sx + 1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps
  // --------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_word(input logic [23:0] pix, input bit typed, input box_pix_t want);
    bit       closed;
    box_pix_t res;
    int       gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    words_in++;
    accumulate_pixel(pix, closed, res);
    if (typed) pending_q.push_back(want);
    else if (closed) pending_q.push_back(res);
    // plan the next gap; valid stays high across a burst
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 12);
      gap = $urandom_range(1, 9);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // quiet point: drop valid, every expected word back, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [abd_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= abd_pkg::CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      abd_pkg::REG_IN_WIDTH:  width_reg  = val & 32'h7FFF;
      abd_pkg::REG_IN_HEIGHT: height_reg = val & 32'h7FFF;
      abd_pkg::REG_EDGE_LIM:  edge_reg   = val & 32'h1FFF;
      default: ;
    endcase
    restart_frame();
  endtask

  task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned e,
                           input int count);
    box_pix_t none;
    none = '0;
    drain();
    write_reg(abd_pkg::REG_IN_WIDTH, w);
    write_reg(abd_pkg::REG_IN_HEIGHT, h);
    write_reg(abd_pkg::REG_EDGE_LIM, e);
    phases++;
    for (int k = 0; k < count; k++) send_word(24'($urandom), 1'b0, none);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: its own stall pattern, from always-ready to long holds
  // --------------------------------------------------------------------------
  int stall_mode = 0, mode_left = 0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= $urandom_range(0, 1);
      2:       out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= ($urandom_range(0, 29) != 0) ? out_tready : ~out_tready;
    endcase
  end

  // --------------------------------------------------------------------------
  // Checker: each accepted word against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    box_pix_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[7:0], out_tdata[15:8], out_tdata[23:16],
             out_tdata[35:24], out_tdata[47:36], out_tlast};
      words_out++;
      if (got.last) frames_done++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: rgb %0d/%0d/%0d at (%0d,%0d) last %0b",
                   got.red, got.green, got.blue, got.col, got.row, got.last);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: want rgb %0d/%0d/%0d (%0d,%0d) last %0b, ",
                      "got rgb %0d/%0d/%0d (%0d,%0d) last %0b"},
                     want.red, want.green, want.blue, want.col, want.row, want.last,
                     got.red, got.green, got.blue, got.col, got.row, got.last);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // After reset the frame is 1x1, so every pixel comes straight back at (0,0)
  // with frame end set: channel extremes and bit patterns.
  dir_row_t dir_tab[12] = '{
    '{24'h000000, '{8'h00, 8'h00, 8'h00, 12'd0, 12'd0, 1'b1}},
    '{24'hFFFFFF, '{8'hFF, 8'hFF, 8'hFF, 12'd0, 12'd0, 1'b1}},
    '{24'h0000FF, '{8'hFF, 8'h00, 8'h00, 12'd0, 12'd0, 1'b1}},
    '{24'h00FF00, '{8'h00, 8'hFF, 8'h00, 12'd0, 12'd0, 1'b1}},
    '{24'hFF0000, '{8'h00, 8'h00, 8'hFF, 12'd0, 12'd0, 1'b1}},
    '{24'hAA55AA, '{8'hAA, 8'h55, 8'hAA, 12'd0, 12'd0, 1'b1}},
    '{24'h55AA55, '{8'h55, 8'hAA, 8'h55, 12'd0, 12'd0, 1'b1}},
    '{24'h7F8001, '{8'h01, 8'h80, 8'h7F, 12'd0, 12'd0, 1'b1}},
    '{24'h01FE80, '{8'h80, 8'hFE, 8'h01, 12'd0, 12'd0, 1'b1}},
    '{24'hFF00FF, '{8'hFF, 8'h00, 8'hFF, 12'd0, 12'd0, 1'b1}},
    '{24'h123456, '{8'h56, 8'h34, 8'h12, 12'd0, 12'd0, 1'b1}},
    '{24'hEDCBA9, '{8'hA9, 8'hCB, 8'hED, 12'd0, 12'd0, 1'b1}}
  };

  initial begin
    box_pix_t none;
    int unsigned w, h, e;
    none = '0;
    restart_frame();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_word(dir_tab[i].pix, 1'b1, dir_tab[i].want);

    // extremes: widest frame (reg above cap), tallest frame, zero sizes,
    // zero edge (sides raised to one), edge above cap, odd ratios
    run_phase(32767, 1, 8191, 40);
    run_phase(1, 32767, 4096, 40);
    run_phase(16384, 2, 4096, 20);
    run_phase(0, 0, 0, 12);
    run_phase(5, 3, 0, 33);
    run_phase(7, 5, 3, 40);
    run_phase(40, 3, 32, 60);
    run_phase(3, 37, 31, 60);

    // random small frames, some downscaled; frames wrap inside a phase
    for (int p = 0; p < 10; p++) begin
      w = $urandom_range(1, 24);
      h = $urandom_range(1, 24);
      case ($urandom_range(0, 3))
        0:       e = 4096;
        1:       e = $urandom_range(0, 8191);
        default: e = $urandom_range(1, 12);
      endcase
      run_phase(w, h, e, $urandom_range(50, 80));
    end

    drain();
    $display("%0d pixels in, %0d pixels out, %0d frame ends over %0d register settings",
             words_in, words_out, frames_done, phases);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatching words", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

  // hard stop: each register setting costs a clearing pass of the line sums
  initial begin
    #20_000_000;
    $display("timeout with %0d words outstanding", pending_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/abd_pkg.sv
rtl/abd_div.sv
rtl/abd_ctrl.sv
rtl/abd_datapath.sv
rtl/area_box_downscaler_unit.sv
sim/testbench.sv
